FILE: rtl/generational_handle_allocator_macros.svh
// ----------------------------------------------------------------------------
// Generational handle allocator - assertion macros
// Shorthand for clocked implications, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define GHA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("handle allocator assertion failed");

// next-cycle implication
`define GHA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("handle allocator assertion failed");

`endif

FILE: rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared constants and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

   // beat field widths
   localparam int REQ_W    = 3;
   localparam int IDX_BITS = 10;
   localparam int VER_BITS = 16;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int PAD_W    = DATA_W - IDX_BITS - VER_BITS;

   // parameter defaults
   localparam int DEF_SLOTS        = 1024;
   localparam int DEF_VERSION_BITS = 16;

   // request kinds
   localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SCAN   = 3'd4;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REJ = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXH = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/generational_handle_allocator.sv
// Request flow: a beat is taken in S_IDLE and decoded; a new-slot create, clear or bad handle goes
//   straight to the response; free / check read the version RAM first; a reusing create pops the
//   free stack, then reads the slot version; a scan reads and checks slots in turn until one is
//   alive or it runs past the end. Throughput: one request at a time; the next beat is taken once
//   the result is handed to the output register. Reset (synchronous, high) zeroes the slot and
//   free counters and the control state only; the RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out (index, version) handles from a version table with a LIFO free
// stack; frees, checks and scans handles and clears the table under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator
   import gha_pkg::*;
#(
   parameter int SLOTS        = DEF_SLOTS,
   parameter int VERSION_BITS = DEF_VERSION_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request beat
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [DATA_W-1:0]   req_tdata,   // [9:0] slot_index, [25:10] slot_version
   input  wire logic [REQ_W-1:0]    req_tuser,   // [2:0] req_type
   // response beat
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [DATA_W-1:0]   rsp_tdata,   // [9:0] out_index, [25:10] out_version
   output logic      [STATUS_W-1:0] rsp_tuser    // [1:0] status
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > IDX_BITS) ? CNT_W : IDX_BITS;
   localparam int VCMP_W = (VERSION_BITS > VER_BITS) ? VERSION_BITS : VER_BITS;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_POP    = 3'd2;  // free-stack top arrives
   localparam logic [2:0] S_CR_UPD = 3'd3;  // reused slot version arrives
   localparam logic [2:0] S_HD_CHK = 3'd4;  // handle version arrives
   localparam logic [2:0] S_SC_RD  = 3'd5;
   localparam logic [2:0] S_SC_CHK = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    free_ff, free_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [REQ_W-1:0]    kind_ff, kind_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [VER_BITS-1:0] ver_ff, ver_in;

   // result waiting for the output register
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic [IDX_BITS-1:0] res_idx_ff, res_idx_in;
   logic [VER_BITS-1:0] res_ver_ff, res_ver_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic [IDX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic [VER_BITS-1:0] rsp_ver_ff, rsp_ver_in;

   // RAM ports
   logic                    vt_we, vt_re;
   logic [IDX_W-1:0]        vt_waddr, vt_raddr;
   logic [VERSION_BITS-1:0] vt_wdata, vt_rdata;
   logic                    fs_we, fs_re;
   logic [IDX_W-1:0]        fs_waddr, fs_raddr;
   logic [IDX_W-1:0]        fs_wdata, fs_rdata;

   logic                    req_acc;
   logic                    rsp_free;
   logic [VERSION_BITS-1:0] ver_next;
   logic                    ver_at_limit;
   logic                    handle_match;
   logic                    idx_in_use;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // shared version unit: bump, limit test, handle compare
   assign ver_next     = vt_rdata + VERSION_BITS'(1);
   assign ver_at_limit = &vt_rdata[VERSION_BITS-1:1];
   assign handle_match = vt_rdata[0] && (VCMP_W'(vt_rdata) == VCMP_W'(ver_ff));
   assign idx_in_use   = CMP_W'(idx_ff) < CMP_W'(used_ff);

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      free_in    = free_ff;
      scan_in    = scan_ff;
      slot_in    = slot_ff;
      kind_in    = kind_ff;
      idx_in     = idx_ff;
      ver_in     = ver_ff;
      res_st_in  = res_st_ff;
      res_idx_in = res_idx_ff;
      res_ver_in = res_ver_ff;
      vt_we      = 1'b0;
      vt_waddr   = slot_ff;
      vt_wdata   = ver_next;
      vt_re      = 1'b0;
      vt_raddr   = IDX_W'(idx_ff);
      fs_we      = 1'b0;
      fs_waddr   = IDX_W'(free_ff);
      fs_wdata   = IDX_W'(idx_ff);
      fs_re      = 1'b0;
      fs_raddr   = IDX_W'(free_ff - CNT_W'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               kind_in  = req_tuser;
               idx_in   = req_tdata[IDX_BITS-1:0];
               ver_in   = req_tdata[IDX_BITS +: VER_BITS];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // default: rejected, no handle
            res_st_in  = ST_REJ;
            res_idx_in = '0;
            res_ver_in = '0;
            state_in   = S_RESP;
            case (kind_ff) inside
               REQ_CREATE: begin
                  if (free_ff != '0) begin
                     fs_re    = 1'b1;
                     state_in = S_POP;
                  end else if (used_ff == CNT_W'(SLOTS)) begin
                     res_st_in = ST_EXH;
                  end else begin
                     // append a fresh slot, version 1
                     vt_we      = 1'b1;
                     vt_waddr   = IDX_W'(used_ff);
                     vt_wdata   = VERSION_BITS'(1);
                     used_in    = used_ff + CNT_W'(1);
                     res_st_in  = ST_OK;
                     res_idx_in = IDX_BITS'(used_ff);
                     res_ver_in = VER_BITS'(1);
                  end
               end
               REQ_FREE, REQ_CHECK: begin
                  if (idx_in_use) begin
                     vt_re    = 1'b1;
                     state_in = S_HD_CHK;
                  end
               end
               REQ_CLEAR: begin
                  used_in   = '0;
                  free_in   = '0;
                  res_st_in = ST_OK;
               end
               REQ_SCAN: begin
                  if (idx_in_use) begin
                     scan_in  = CNT_W'(idx_ff);
                     state_in = S_SC_RD;
                  end
               end
               default: ;
            endcase
         end
         S_POP: begin
            slot_in  = fs_rdata;
            vt_re    = 1'b1;
            vt_raddr = fs_rdata;
            state_in = S_CR_UPD;
         end
         S_CR_UPD: begin
            if (ver_at_limit) begin
               // slot stays on the stack
               res_st_in = ST_EXH;
            end else begin
               vt_we      = 1'b1;
               free_in    = free_ff - CNT_W'(1);
               res_st_in  = ST_OK;
               res_idx_in = IDX_BITS'(slot_ff);
               res_ver_in = VER_BITS'(ver_next);
            end
            state_in = S_RESP;
         end
         S_HD_CHK: begin
            res_st_in = handle_match ? ST_OK : ST_REJ;
            if (handle_match && (kind_ff == REQ_FREE)) begin
               vt_we    = 1'b1;
               vt_waddr = IDX_W'(idx_ff);
               if (free_ff < CNT_W'(SLOTS)) begin
                  fs_we   = 1'b1;
                  free_in = free_ff + CNT_W'(1);
               end
            end
            state_in = S_RESP;
         end
         S_SC_RD: begin
            if (scan_ff < used_ff) begin
               vt_re    = 1'b1;
               vt_raddr = IDX_W'(scan_ff);
               state_in = S_SC_CHK;
            end else begin
               state_in = S_RESP;   // ran off the end, status stays rejected
            end
         end
         S_SC_CHK: begin
            if (vt_rdata[0]) begin
               res_st_in  = ST_OK;
               res_idx_in = IDX_BITS'(scan_ff);
               res_ver_in = VER_BITS'(vt_rdata);
               state_in   = S_RESP;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = S_SC_RD;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: loads from the result when the sequencer hands it over
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_st_in    = rsp_st_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ver_in   = rsp_ver_ff;
      if ((state_ff == S_RESP) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_st_in    = res_st_ff;
         rsp_idx_in   = res_idx_ff;
         rsp_ver_in   = res_ver_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      slot_ff    <= slot_in;
      kind_ff    <= kind_in;
      idx_ff     <= idx_in;
      ver_ff     <= ver_in;
      res_st_ff  <= res_st_in;
      res_idx_ff <= res_idx_in;
      res_ver_ff <= res_ver_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_ver_ff <= rsp_ver_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ver_ff, rsp_idx_ff};

   // per-slot versions
   gha_ram #(
      .WIDTH (VERSION_BITS),
      .DEPTH (SLOTS)
   ) u_version_ram (
      .clock   (clock),
      .wr_en   (vt_we),
      .wr_addr (vt_waddr),
      .wr_data (vt_wdata),
      .rd_en   (vt_re),
      .rd_addr (vt_raddr),
      .rd_data (vt_rdata)
   );

   // LIFO of freed slot indices
   gha_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOTS)
   ) u_free_stack_ram (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fs_waddr),
      .wr_data (fs_wdata),
      .rd_en   (fs_re),
      .rd_addr (fs_raddr),
      .rd_data (fs_rdata)
   );

endmodule

`default_nettype wire

FILE: rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of the generational handle allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_allocator_macros.svh"

module gha_checker
   import gha_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic [DATA_W-1:0]   req_tdata,
   input wire logic [REQ_W-1:0]    req_tuser,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [DATA_W-1:0]   rsp_tdata,
   input wire logic [STATUS_W-1:0] rsp_tuser
);

   // only defined status codes leave the block
   `GHA_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid,
      (rsp_tuser == ST_OK) || (rsp_tuser == ST_REJ) || (rsp_tuser == ST_EXH))

   // failed requests carry no handle
   `GHA_ASSERT_IMP(a_fail_no_handle, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK),
      rsp_tdata == '0)

   // a returned handle is always alive (odd version)
   `GHA_ASSERT_IMP(a_handle_alive, clock, reset,
      rsp_tvalid && (rsp_tuser == ST_OK) && (rsp_tdata[IDX_BITS +: VER_BITS] != '0),
      rsp_tdata[IDX_BITS])

   // one request at a time
   `GHA_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // stalled response holds
   `GHA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);

`default_nettype wire
